[rtl/gpip_pkg.sv]
// ---------------------------------------------------------------------------
// gpip_pkg
// Shared types and constants for the geographic point-in-polygon block.
// ---------------------------------------------------------------------------
package gpip_pkg;

  // Stream widths
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 8;

  // Field widths
  localparam int LAT_W = 24;
  localparam int LON_W = 26;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  // Wrapped longitude width, and the products of the crossing test
  localparam int WLON_W = 27;
  localparam int PROD_W = 53;

  // Item kinds carried on tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TEST  = 1'b1;

  // Register index decoded from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // Degrees times 65536
  localparam logic signed [WLON_W-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [WLON_W-1:0] DEG360 = 27'sd23592960;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_en;     // store the incoming vertex
    logic start;     // latch the test point, clear the parity
    logic rd_en;     // read one table entry
    logic edge_rd;   // the read closes an edge (not the priming read)
    logic load_res;  // move the verdict into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic busy;      // edge pipeline still holds reads in flight
  } sts_t;

endpackage

[rtl/gpip_ctrl.sv]
// ---------------------------------------------------------------------------
// gpip_ctrl
// Sequencer for vertex writes and the edge walk of a point test.
// ---------------------------------------------------------------------------
module gpip_ctrl #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic                         action,
  input  logic [gpip_pkg::CNT_W-1:0]   vertex_count,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output gpip_pkg::cmd_t               cmd,
  output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
  input  gpip_pkg::sts_t               sts
);
  import gpip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = AW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t          state;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   n_use;
  logic [CW-1:0]   n_last;
  logic            out_free;

  // Clamp the vertex count to the table depth
  assign n_use  = (32'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vertex_count);
  assign n_last = n_use - CW'(1);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign rd_addr  = idx[AW-1:0];

  // Decode commands from the state
  always_comb begin
    cmd          = '0;
    cmd.wr_en    = (state == ST_IDLE) && s_tvalid && (action == ACT_WRITE);
    cmd.start    = (state == ST_IDLE) && s_tvalid && (action == ACT_TEST);
    cmd.rd_en    = (state == ST_PRIME) || (state == ST_WALK);
    cmd.edge_rd  = (state == ST_WALK);
    cmd.load_res = (state == ST_DONE) && out_free;
  end

  // Advance state, walk index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && (action == ACT_TEST)) begin
            if (n_use == '0) begin
              state <= ST_DONE;
            end else begin
              idx   <= n_last;
              state <= ST_PRIME;
            end
          end
        end
        ST_PRIME: begin
          idx   <= '0;
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (idx == n_last) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_DRAIN: begin
          if (!sts.busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/gpip_dp.sv]
// ---------------------------------------------------------------------------
// gpip_dp
// Vertex table, longitude wrap and the pipelined edge-crossing test.
// ---------------------------------------------------------------------------
module gpip_dp #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gpip_pkg::cmd_t                       cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0]      rd_addr,
  output gpip_pkg::sts_t                       sts,
  input  logic [gpip_pkg::IDX_W-1:0]           vertex_index,
  input  logic signed [gpip_pkg::LAT_W-1:0]    point_lat,
  input  logic signed [gpip_pkg::LON_W-1:0]    point_lon,
  output logic                                 inside_res
);
  import gpip_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int ENT_W = LAT_W + LON_W;

  // Vertex table: latitude in the upper bits, longitude in the lower
  logic [ENT_W-1:0] mem [0:MAX_VERTICES-1];
  logic [ENT_W-1:0] rd_q;
  logic [ENT_W-1:0] prev;
  logic             wr_ok;

  // Test point, both wrap candidates
  logic signed [LAT_W-1:0]  plat;
  logic signed [WLON_W-1:0] plon_a;
  logic signed [WLON_W-1:0] plon_b;
  logic signed [WLON_W-1:0] plon_in;

  // Pipeline control
  logic rv_valid, rv_edge;
  logic s1_occ, s2_occ;
  logic s1_hit, s2_hit;

  // Edge operands
  logic signed [LAT_W-1:0]  yi, yj;
  logic signed [LON_W-1:0]  xi, xj;
  logic                     straddle;

  // Stage 1
  logic signed [LAT_W:0]    d_s1, dlat_s1;
  logic signed [WLON_W:0]   dxa_s1, dxb_s1;
  logic signed [WLON_W-1:0] dxj_s1;

  // Stage 2
  logic signed [PROD_W-1:0] lhs_a, lhs_b, rhs;
  logic                     dpos;
  logic                     cross_a, cross_b;

  // Verdict accumulators
  logic anyneg, par_a, par_b;

  assign wr_ok   = 32'(vertex_index) < MAX_VERTICES;
  assign plon_in = WLON_W'(point_lon);

  // Write and read the table
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[AW'(vertex_index)] <= {point_lat, point_lon};
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Current entry closes the edge from the held previous entry
  assign yi = rd_q[ENT_W-1:LON_W];
  assign xi = rd_q[LON_W-1:0];
  assign yj = prev[ENT_W-1:LON_W];
  assign xj = prev[LON_W-1:0];
  assign straddle = (yi > plat) != (yj > plat);

  // Latch the test point with both longitude wraps
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      plat   <= point_lat;
      plon_a <= (plon_in > DEG180) ? plon_in - DEG360 : plon_in;
      plon_b <= (plon_in < 0) ? plon_in + DEG360 : plon_in;
    end
  end

  // Pipeline occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      rv_valid <= 1'b0;
      rv_edge  <= 1'b0;
      s1_occ   <= 1'b0;
      s2_occ   <= 1'b0;
    end else begin
      rv_valid <= cmd.rd_en;
      rv_edge  <= cmd.edge_rd;
      s1_occ   <= rv_valid;
      s2_occ   <= s1_occ;
    end
  end

  assign sts.busy = rv_valid || s1_occ || s2_occ;

  // Stage 1: differences of the edge against the point
  always_ff @(posedge clk) begin
    if (rv_valid) begin
      prev    <= rd_q;
      s1_hit  <= rv_edge && straddle;
      d_s1    <= (LAT_W+1)'(yj) - (LAT_W+1)'(yi);
      dlat_s1 <= (LAT_W+1)'(plat) - (LAT_W+1)'(yi);
      dxa_s1  <= (WLON_W+1)'(plon_a) - (WLON_W+1)'(xi);
      dxb_s1  <= (WLON_W+1)'(plon_b) - (WLON_W+1)'(xi);
      dxj_s1  <= WLON_W'(xj) - WLON_W'(xi);
    end else begin
      s1_hit  <= 1'b0;
    end
  end

  // Stage 2: cross-multiply
  always_ff @(posedge clk) begin
    s2_hit <= s1_hit;
    lhs_a  <= dxa_s1 * d_s1;
    lhs_b  <= dxb_s1 * d_s1;
    rhs    <= dxj_s1 * dlat_s1;
    dpos   <= d_s1 > 0;
  end

  assign cross_a = dpos ? (lhs_a < rhs) : (lhs_a > rhs);
  assign cross_b = dpos ? (lhs_b < rhs) : (lhs_b > rhs);

  // Stage 3: toggle parity, track negative vertex longitudes
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      anyneg <= 1'b0;
      par_a  <= 1'b0;
      par_b  <= 1'b0;
    end else begin
      if (rv_valid && rv_edge && xi[LON_W-1]) begin
        anyneg <= 1'b1;
      end
      if (s2_hit && cross_a) begin
        par_a <= !par_a;
      end
      if (s2_hit && cross_b) begin
        par_b <= !par_b;
      end
    end
  end

  // Hold the verdict for the output word
  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      inside_res <= anyneg ? par_a : par_b;
    end
  end

endmodule

[rtl/geographic_point_in_polygon.sv]
// ---------------------------------------------------------------------------
// geographic_point_in_polygon
// Crossing-number point-in-polygon test on fixed-point latitude/longitude.
// ---------------------------------------------------------------------------
// A vertex write (tuser = 0) stores one vertex. A point test (tuser = 1)
// walks the closed polygon of the first n vertices, n being vertex_count
// clamped to MAX_VERTICES, and returns one word with the inside flag; when
// n is zero it returns that word without reading the table. The single
// read port of the vertex table paces the walk: one priming read of the
// closing vertex, then one entry a cycle, then a drain of the
// difference/multiply/compare pipeline and the load of the output register.
// The input side is ready again in the cycle after the result is loaded,
// even while that word still waits to be taken. Set vertex_count only
// while the block is idle, and test only after every slot in use has been
// written.
// ---------------------------------------------------------------------------
module geographic_point_in_polygon #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gpip_pkg::S_TDATA_W-1:0]    s_tdata,  // vertex_index[5:0], point_lat[29:6],
                                                      // point_lon[55:30]
  input  logic [0:0]                        s_tuser,  // action[0]
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gpip_pkg::M_TDATA_W-1:0]    m_tdata,  // inside_res[0], zeros above
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import gpip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  logic [CNT_W-1:0]        vertex_count;
  logic                    action;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [LAT_W-1:0] point_lat;
  logic signed [LON_W-1:0] point_lon;
  logic                    inside_res;
  cmd_t                    cmd;
  sts_t                    sts;
  logic [AW-1:0]           rd_addr;

  // Unpack the input word
  assign action       = s_tuser[0];
  assign vertex_index = s_tdata[5:0];
  assign point_lat    = s_tdata[29:6];
  assign point_lon    = s_tdata[55:30];

  assign m_tdata = {(M_TDATA_W-1)'(0), inside_res};

  // Register write and read-back
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {(32-CNT_W)'(0), vertex_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT)) begin
      vertex_count <= pwdata[CNT_W-1:0];
    end
  end

  gpip_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .action       (action),
    .vertex_count (vertex_count),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .sts          (sts)
  );

  gpip_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .sts          (sts),
    .vertex_index (vertex_index),
    .point_lat    (point_lat),
    .point_lon    (point_lon),
    .inside_res   (inside_res)
  );

endmodule

[rtl/gpip_checker.sv]
// ---------------------------------------------------------------------------
// gpip_checker
// Port-level checks of the point-in-polygon block over time.
// ---------------------------------------------------------------------------
module gpip_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [0:0]                     s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [gpip_pkg::M_TDATA_W-1:0] m_tdata
);
  import gpip_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // A test occupies the block after acceptance
  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == ACT_TEST) |=> !s_tready)
    else $error("input ready right after a test was accepted");

  // A vertex write leaves the block ready
  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == ACT_WRITE) |=> s_tready)
    else $error("input not ready after a vertex write");

  // No result appears in the cycle right after a test is accepted
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == ACT_TEST) |=> !$rose(m_tvalid))
    else $error("result word appeared too early");

  // Padding bits of the result word stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_TDATA_W-1:1] == '0))
    else $error("result padding bits not zero");

endmodule

bind geographic_point_in_polygon gpip_checker u_gpip_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
